FILE: rtl/core/pbt_pkg.sv
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types and constants for the projectile burst tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pbt_pkg;

   localparam int MAX_BURSTS = 16;
   localparam int IDX_W      = $clog2(MAX_BURSTS);
   localparam int CNT_W      = $clog2(MAX_BURSTS + 1);

   // gravity, Q4.12 m/s^2
   localparam logic [15:0] G_DOWN_Q12 = 16'd40150;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] ST_ACTIVE = 2'd0;
   localparam logic [1:0] ST_HIT    = 2'd1;
   localparam logic [1:0] ST_MISS   = 2'd2;

   localparam logic CSR_MAX_TOF    = 1'b0;
   localparam logic CSR_HIT_RADIUS = 1'b1;

   localparam logic [23:0] MAX_TOF_RST    = 24'd196608;
   localparam logic [7:0]  HIT_RADIUS_RST = 8'd10;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic signed [23:0] vz;
      logic [15:0]        dt;
      logic               target_present;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] lead_x;
      logic signed [31:0] lead_y;
      logic signed [31:0] lead_z;
      logic signed [23:0] lead_vx;
      logic signed [23:0] lead_vy;
      logic signed [23:0] lead_vz;
      logic [23:0]        lead_flight_time;
      logic [4:0]         new_hits;
      logic [4:0]         active_bursts;
      logic               detonated;
      logic               impact;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic [23:0]        tof;
      logic [1:0]         status;
   } entry_type;

   // per-tick constants held by the sequencer
   typedef struct packed {
      logic [15:0]        dt;
      logic [15:0]        dv;
      logic               target;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic [19:0]        lim;
      logic [23:0]        max_tof;
   } tick_type;

   // one finished entry leaving the update pipe
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
      logic             was_active;
      logic             new_hit;
      logic             counted;
      logic             is_hit;
   } res_type;

endpackage
`default_nettype wire

FILE: rtl/core/pbt_ram.sv
// ----------------------------------------------------------------------------
// pbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/pbt_update.sv
// ----------------------------------------------------------------------------
// pbt_update
// Six-stage per-entry pipe: gravity, motion, flight time, hit test, aging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pbt_update
   import pbt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [IDX_W-1:0] in_addr,
   input  wire entry_type        in_entry,
   input  wire tick_type         tick,
   output res_type               res
);
   // valid and address shift line
   logic [4:0]       v_ff, v_in;
   logic [IDX_W-1:0] a_ff [5];
   entry_type        e1_ff, e2_ff, e3_ff, e4_ff, e5_ff;

   // stage 1: gravity
   logic signed [24:0] vz_sum;
   entry_type          e1_in;
   // stage 2: products
   logic signed [40:0] px_ff, py_ff, pz_ff;
   // stage 3: motion
   logic signed [40:0] rx, ry, rz;
   logic [24:0]        tof_sum;
   entry_type          e3_in;
   // stage 4: distances
   logic signed [32:0] dx, dy, dz;
   logic [2:0]         near;
   logic               near_ff;
   logic [19:0]        ax_ff, ay_ff, az_ff;
   logic signed [20:0] lim_s;
   // stage 5: squares
   logic [39:0]        sx_ff, sy_ff, sz_ff;
   logic               near5_ff;
   // stage 6
   logic [41:0]        dist2;
   logic [39:0]        lim2;
   logic               act, hit_now;

   function automatic logic [19:0] mag20(input logic signed [32:0] d);
      logic signed [32:0] n;
      n = d[32] ? -d : d;
      return n[19:0];
   endfunction

   function automatic logic near_axis(input logic signed [32:0] d,
                                      input logic signed [20:0] l);
      return (d < 33'(l)) && (d > -33'(l));
   endfunction

   assign v_in = {v_ff[3:0], in_valid};

   always_comb begin
      vz_sum = 25'(in_entry.vel_z) + $signed({9'd0, tick.dv});
      e1_in  = in_entry;
      if (in_entry.status == ST_ACTIVE) begin
         e1_in.vel_z = (vz_sum[24] != vz_sum[23]) ? 24'sh7FFFFF : vz_sum[23:0];
      end
   end

   always_comb begin
      rx      = (px_ff + 41'sd32768) >>> 16;
      ry      = (py_ff + 41'sd32768) >>> 16;
      rz      = (pz_ff + 41'sd32768) >>> 16;
      tof_sum = {1'b0, e2_ff.tof} + {9'd0, tick.dt};
      e3_in   = e2_ff;
      if (e2_ff.status == ST_ACTIVE) begin
         e3_in.pos_x = e2_ff.pos_x + rx[31:0];
         e3_in.pos_y = e2_ff.pos_y + ry[31:0];
         e3_in.pos_z = e2_ff.pos_z + rz[31:0];
         e3_in.tof   = tof_sum[24] ? 24'hFFFFFF : tof_sum[23:0];
      end
   end

   always_comb begin
      lim_s = $signed({1'b0, tick.lim});
      dx    = 33'(e3_ff.pos_x) - 33'(tick.tx);
      dy    = 33'(e3_ff.pos_y) - 33'(tick.ty);
      dz    = 33'(e3_ff.pos_z) - 33'(tick.tz);
      near  = {near_axis(dx, lim_s), near_axis(dy, lim_s), near_axis(dz, lim_s)};
   end

   always_comb begin
      dist2   = {2'b0, sx_ff} + {2'b0, sy_ff} + {2'b0, sz_ff};
      lim2    = tick.lim * tick.lim;
      hit_now = (e5_ff.status == ST_ACTIVE) && tick.target && near5_ff
                && (dist2 < {2'b0, lim2});
      act     = (e5_ff.status == ST_ACTIVE) && !hit_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         res.valid <= 1'b0;
      end else begin
         v_ff      <= v_in;
         res.valid <= v_ff[4];
      end
      a_ff[0] <= in_addr;
      for (int s = 1; s < 5; s++) begin
         a_ff[s] <= a_ff[s-1];
      end
      e1_ff    <= e1_in;
      e2_ff    <= e1_ff;
      px_ff    <= e1_ff.vel_x * $signed({1'b0, tick.dt});
      py_ff    <= e1_ff.vel_y * $signed({1'b0, tick.dt});
      pz_ff    <= e1_ff.vel_z * $signed({1'b0, tick.dt});
      e3_ff    <= e3_in;
      e4_ff    <= e3_ff;
      near_ff  <= &near;
      ax_ff    <= mag20(dx);
      ay_ff    <= mag20(dy);
      az_ff    <= mag20(dz);
      e5_ff    <= e4_ff;
      near5_ff <= near_ff;
      sx_ff    <= ax_ff * ax_ff;
      sy_ff    <= ay_ff * ay_ff;
      sz_ff    <= az_ff * az_ff;

      res.addr       <= a_ff[4];
      res.entry      <= e5_ff;
      res.was_active <= (e5_ff.status == ST_ACTIVE);
      res.new_hit    <= hit_now;
      res.counted    <= act;
      res.is_hit     <= hit_now || (e5_ff.status == ST_HIT);
      if (hit_now) begin
         res.entry.status <= ST_HIT;
      end else if (act && (e5_ff.tof >= tick.max_tof)) begin
         res.entry.status <= ST_MISS;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/projectile_burst_tracker.sv
// ----------------------------------------------------------------------------
// projectile_burst_tracker
// Table of projectile bursts held in one RAM, stepped by a tick sequencer.
// ----------------------------------------------------------------------------
// Add, clear and a tick after detonation go from S_IDLE to S_FIN; the result
// beat is registered from S_FIN. A tick streams the table through the 6-stage
// update pipe, one entry a cycle, then waits in S_WAIT until every result is
// back. One item at a time; busy stays high until the result beat is issued.
// Synchronous reset empties the table and clears the flags; the CSRs go to
// their defaults. The receiver cannot stall: each beat is a one-cycle strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module projectile_burst_tracker
   import pbt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_wdata
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] cmp_cnt_ff, cmp_cnt_in;
   logic [CNT_W-1:0] act_ff, act_in, hits_ff, hits_in, new_ff, new_in;
   logic             done_ff, done_in, impact_ff, impact_in;
   logic             acc_ff, acc_in;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic [23:0]      max_tof_ff;
   logic [7:0]       radius_ff;
   tick_type         tick_ff;
   entry_type        lead_ff, new_entry, rd_data;
   res_type          res;
   rsp_type          rsp_in;
   logic             accept, rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [31:0]      dv_full;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // gravity step per tick, rounded
   assign dv_full = G_DOWN_Q12 * req_payload.dt + 32'd32768;

   always_comb begin
      new_entry        = '0;
      new_entry.pos_x  = req_payload.x;
      new_entry.pos_y  = req_payload.y;
      new_entry.pos_z  = req_payload.z;
      new_entry.vel_x  = req_payload.vx;
      new_entry.vel_y  = req_payload.vy;
      new_entry.vel_z  = req_payload.vz;
      new_entry.status = ST_ACTIVE;
   end

   // single write port: adds in idle, pipe write-back during a tick
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = new_entry;
      if (res.valid) begin
         wr_en   = res.was_active;
         wr_addr = res.addr;
         wr_data = res.entry;
      end else if (accept && (req_payload.kind == KIND_ADD)
                   && (count_ff < CNT_W'(MAX_BURSTS))) begin
         wr_en = 1'b1;
      end
   end

   assign rd_en = (state_ff == S_READ) && (rd_cnt_ff < count_ff);

   pbt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_BURSTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   pbt_update u_update (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_addr  (rd_addr_ff),
      .in_entry (rd_data),
      .tick     (tick_ff),
      .res      (res)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_cnt_in  = rd_cnt_ff;
      cmp_cnt_in = cmp_cnt_ff;
      act_in     = act_ff;
      hits_in    = hits_ff;
      new_in     = new_ff;
      done_in    = done_ff;
      impact_in  = impact_ff;
      acc_in     = acc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in     = '0;
               hits_in    = '0;
               new_in     = '0;
               acc_in     = 1'b0;
               rd_cnt_in  = '0;
               cmp_cnt_in = '0;
               state_in   = S_FIN;
               priority case (req_payload.kind)
                  KIND_ADD: begin
                     if (count_ff < CNT_W'(MAX_BURSTS)) begin
                        count_in = count_ff + 1'b1;
                        acc_in   = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     if (!done_ff) begin
                        state_in = S_READ;
                     end
                  end
                  KIND_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_READ, S_WAIT: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rd_cnt_in == count_ff) begin
               state_in = S_WAIT;
            end
            if (res.valid) begin
               cmp_cnt_in = cmp_cnt_ff + 1'b1;
               act_in     = act_ff + CNT_W'(res.counted);
               hits_in    = hits_ff + CNT_W'(res.is_hit);
               new_in     = new_ff + CNT_W'(res.new_hit);
            end
            if ((state_ff == S_WAIT) && (cmp_cnt_ff == count_ff)) begin
               state_in = S_FIN;
               if (act_ff == '0) begin
                  done_in   = 1'b1;
                  impact_in = (hits_ff != '0);
               end
            end
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in                  = '0;
      rsp_in.accepted         = acc_ff;
      rsp_in.new_hits         = 5'(new_ff);
      rsp_in.active_bursts    = 5'(act_ff);
      rsp_in.detonated        = done_ff;
      rsp_in.impact           = impact_ff;
      if (count_ff != '0) begin
         rsp_in.lead_x           = lead_ff.pos_x;
         rsp_in.lead_y           = lead_ff.pos_y;
         rsp_in.lead_z           = lead_ff.pos_z;
         rsp_in.lead_vx          = lead_ff.vel_x;
         rsp_in.lead_vy          = lead_ff.vel_y;
         rsp_in.lead_vz          = lead_ff.vel_z;
         rsp_in.lead_flight_time = lead_ff.tof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         done_ff     <= 1'b0;
         impact_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
         max_tof_ff  <= MAX_TOF_RST;
         radius_ff   <= HIT_RADIUS_RST;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         done_ff     <= done_in;
         impact_ff   <= impact_in;
         rd_valid_ff <= rd_en;
         rsp_valid   <= (state_ff == S_FIN);
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAX_TOF:    max_tof_ff <= csr_wdata;
               CSR_HIT_RADIUS: radius_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      rd_cnt_ff  <= rd_cnt_in;
      cmp_cnt_ff <= cmp_cnt_in;
      act_ff     <= act_in;
      hits_ff    <= hits_in;
      new_ff     <= new_in;
      acc_ff     <= acc_in;
      rd_addr_ff <= rd_cnt_ff[IDX_W-1:0];
      if (state_ff == S_FIN) begin
         rsp_payload <= rsp_in;
      end
      // entry 0 shadow for the lead fields
      if (wr_en && (wr_addr == '0)) begin
         lead_ff <= wr_data;
      end
      if (accept) begin
         tick_ff.dt      <= req_payload.dt;
         tick_ff.dv      <= dv_full[31:16];
         tick_ff.target  <= req_payload.target_present;
         tick_ff.tx      <= req_payload.x;
         tick_ff.ty      <= req_payload.y;
         tick_ff.tz      <= req_payload.z;
         tick_ff.lim     <= {radius_ff, 12'd0};
         tick_ff.max_tof <= max_tof_ff;
      end
   end
endmodule
`default_nettype wire
